FILE: rtl/ll1er_pkg.sv
package ll1er_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// grammar symbols as held on the stack
	typedef logic [3:0] sym_t;
	localparam sym_t SYM_NONE = 4'd0;
	localparam sym_t SYM_END  = 4'd1;
	localparam sym_t SYM_E    = 4'd2;
	localparam sym_t SYM_EP   = 4'd3;
	localparam sym_t SYM_T    = 4'd4;
	localparam sym_t SYM_TP   = 4'd5;
	localparam sym_t SYM_F    = 4'd6;
	localparam sym_t SYM_ID   = 4'd7;
	localparam sym_t SYM_ADD  = 4'd8;
	localparam sym_t SYM_SUB  = 4'd9;
	localparam sym_t SYM_MUL  = 4'd10;
	localparam sym_t SYM_DIV  = 4'd11;
	localparam sym_t SYM_LP   = 4'd12;
	localparam sym_t SYM_RP   = 4'd13;

	// text bytes that are terminals
	localparam logic [7:0] CH_LP  = 8'h28;
	localparam logic [7:0] CH_RP  = 8'h29;
	localparam logic [7:0] CH_ID  = 8'h69;
	localparam logic [7:0] CH_ADD = 8'h2b;
	localparam logic [7:0] CH_SUB = 8'h2d;
	localparam logic [7:0] CH_MUL = 8'h2a;
	localparam logic [7:0] CH_DIV = 8'h2f;

	// result codes
	localparam logic [1:0] STATUS_BUSY   = 2'd0;
	localparam logic [1:0] STATUS_ACCEPT = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// what one step of the automaton does with the current top
	typedef enum logic [2:0] {
		ACT_DONE,
		ACT_ERROR,
		ACT_EXP1,
		ACT_EXP2,
		ACT_EXP3,
		ACT_POP,
		ACT_MATCH
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PUSH2,
		ST_LOAD_EVAL,
		ST_LOAD_FIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic eval;
		logic push2;
		logic load;
		logic finish;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/ll1er_in_if.sv
interface ll1er_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

FILE: rtl/ll1er_out_if.sv
interface ll1er_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

FILE: rtl/ll1er_ctrl.sv
module ll1er_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ll1er_pkg::stat_t   stat,
	output ll1er_pkg::cmd_t    cmd
);

	ll1er_pkg::state_t state_q;
	ll1er_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ll1er_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ll1er_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ll1er_pkg::ST_EVAL;
				end
			end
			ll1er_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				case (stat.act)
					ll1er_pkg::ACT_EXP1:  state_d = ll1er_pkg::ST_EVAL;
					ll1er_pkg::ACT_EXP2:  state_d = ll1er_pkg::ST_EVAL;
					ll1er_pkg::ACT_EXP3:  state_d = ll1er_pkg::ST_PUSH2;
					ll1er_pkg::ACT_POP:   state_d = ll1er_pkg::ST_LOAD_EVAL;
					ll1er_pkg::ACT_MATCH: state_d = ll1er_pkg::ST_LOAD_FIN;
					default:              state_d = ll1er_pkg::ST_FINISH;
				endcase
			end
			ll1er_pkg::ST_PUSH2: begin
				cmd.push2 = 1'b1;
				state_d   = ll1er_pkg::ST_EVAL;
			end
			ll1er_pkg::ST_LOAD_EVAL: begin
				cmd.load = 1'b1;
				state_d  = ll1er_pkg::ST_EVAL;
			end
			ll1er_pkg::ST_LOAD_FIN: begin
				cmd.load = 1'b1;
				state_d  = ll1er_pkg::ST_FINISH;
			end
			ll1er_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ll1er_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ll1er_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/ll1er_dpath.sv
module ll1er_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         char_code,
	input  logic               end_of_text,
	input  ll1er_pkg::cmd_t    cmd,
	output ll1er_pkg::stat_t   stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status
);

	localparam int SPX_W = ll1er_pkg::SP_W + 1;
	localparam logic [SPX_W-1:0] DEPTH_EXT = SPX_W'(ll1er_pkg::STACK_DEPTH);

	// byte to terminal symbol, none for skipped bytes
	function automatic ll1er_pkg::sym_t classify(input logic [7:0] c);
		ll1er_pkg::sym_t s;
		case (c)
			ll1er_pkg::CH_LP:  s = ll1er_pkg::SYM_LP;
			ll1er_pkg::CH_RP:  s = ll1er_pkg::SYM_RP;
			ll1er_pkg::CH_ID:  s = ll1er_pkg::SYM_ID;
			ll1er_pkg::CH_ADD: s = ll1er_pkg::SYM_ADD;
			ll1er_pkg::CH_SUB: s = ll1er_pkg::SYM_SUB;
			ll1er_pkg::CH_MUL: s = ll1er_pkg::SYM_MUL;
			ll1er_pkg::CH_DIV: s = ll1er_pkg::SYM_DIV;
			default:           s = ll1er_pkg::SYM_NONE;
		endcase
		return s;
	endfunction

	// stack below the top; entry 0 is the end marker and never written
	ll1er_pkg::sym_t mem [ll1er_pkg::STACK_DEPTH];

	ll1er_pkg::sym_t              top_q;
	logic [ll1er_pkg::SP_W-1:0]   sp_q;
	logic                         err_q;
	ll1er_pkg::sym_t              la_q;
	logic                         fin_q;
	ll1er_pkg::sym_t              pend_q;
	ll1er_pkg::sym_t              rdata_q;
	logic                         out_valid_q;
	logic [1:0]                   status_q;

	logic [1:0]                   exp_n;
	ll1er_pkg::sym_t              rhs0;
	ll1er_pkg::sym_t              rhs1;
	ll1er_pkg::sym_t              rhs_top;
	logic                         is_nt;
	logic [SPX_W-1:0]             sp_ext;
	logic [SPX_W-1:0]             new_sp_ext;
	logic [ll1er_pkg::SP_W-1:0]   sp_m1;
	logic [ll1er_pkg::SP_W-1:0]   sp_m2;
	ll1er_pkg::act_t              act;
	logic                         we;
	logic [ll1er_pkg::ADDR_W-1:0] waddr;
	ll1er_pkg::sym_t              wdata;

	// production chosen by the top nonterminal and the lookahead
	always_comb begin
		exp_n   = 2'd0;
		rhs0    = ll1er_pkg::SYM_NONE;
		rhs1    = ll1er_pkg::SYM_NONE;
		rhs_top = ll1er_pkg::SYM_NONE;
		case (top_q)
			ll1er_pkg::SYM_E, ll1er_pkg::SYM_T: begin
				if (la_q == ll1er_pkg::SYM_LP || la_q == ll1er_pkg::SYM_ID) begin
					exp_n   = 2'd2;
					rhs0    = (top_q == ll1er_pkg::SYM_E) ? ll1er_pkg::SYM_EP : ll1er_pkg::SYM_TP;
					rhs_top = (top_q == ll1er_pkg::SYM_E) ? ll1er_pkg::SYM_T : ll1er_pkg::SYM_F;
				end
			end
			ll1er_pkg::SYM_EP: begin
				if (la_q == ll1er_pkg::SYM_ADD || la_q == ll1er_pkg::SYM_SUB) begin
					exp_n   = 2'd3;
					rhs0    = ll1er_pkg::SYM_EP;
					rhs1    = ll1er_pkg::SYM_T;
					rhs_top = la_q;
				end
			end
			ll1er_pkg::SYM_TP: begin
				if (la_q == ll1er_pkg::SYM_MUL || la_q == ll1er_pkg::SYM_DIV) begin
					exp_n   = 2'd3;
					rhs0    = ll1er_pkg::SYM_TP;
					rhs1    = ll1er_pkg::SYM_F;
					rhs_top = la_q;
				end
			end
			ll1er_pkg::SYM_F: begin
				if (la_q == ll1er_pkg::SYM_LP) begin
					exp_n   = 2'd3;
					rhs0    = ll1er_pkg::SYM_RP;
					rhs1    = ll1er_pkg::SYM_E;
					rhs_top = ll1er_pkg::SYM_LP;
				end else if (la_q == ll1er_pkg::SYM_ID) begin
					exp_n   = 2'd1;
					rhs_top = ll1er_pkg::SYM_ID;
				end
			end
			default: begin
				exp_n = 2'd0;
			end
		endcase
	end

	// step decision
	always_comb begin
		is_nt      = top_q inside {[ll1er_pkg::SYM_E:ll1er_pkg::SYM_F]};
		sp_ext     = {1'b0, sp_q};
		new_sp_ext = sp_ext - SPX_W'(1) + SPX_W'(exp_n);
		sp_m1      = sp_q - ll1er_pkg::SP_W'(1);
		sp_m2      = sp_q - ll1er_pkg::SP_W'(2);
		if (err_q || la_q == ll1er_pkg::SYM_NONE) begin
			act = ll1er_pkg::ACT_DONE;
		end else if (sp_q == '0 || sp_ext > DEPTH_EXT) begin
			act = ll1er_pkg::ACT_ERROR;
		end else if (is_nt) begin
			if (exp_n != 2'd0) begin
				if (new_sp_ext > DEPTH_EXT) begin
					act = ll1er_pkg::ACT_ERROR;
				end else if (exp_n == 2'd3) begin
					act = ll1er_pkg::ACT_EXP3;
				end else if (exp_n == 2'd2) begin
					act = ll1er_pkg::ACT_EXP2;
				end else begin
					act = ll1er_pkg::ACT_EXP1;
				end
			end else if (top_q == ll1er_pkg::SYM_EP || top_q == ll1er_pkg::SYM_TP) begin
				act = ll1er_pkg::ACT_POP;
			end else begin
				act = ll1er_pkg::ACT_ERROR;
			end
		end else if (top_q == la_q) begin
			act = (la_q == ll1er_pkg::SYM_END) ? ll1er_pkg::ACT_DONE : ll1er_pkg::ACT_MATCH;
		end else begin
			act = ll1er_pkg::ACT_ERROR;
		end
	end

	// stack write port
	always_comb begin
		we    = 1'b0;
		waddr = sp_m1[ll1er_pkg::ADDR_W-1:0];
		wdata = rhs0;
		if (cmd.eval && (act == ll1er_pkg::ACT_EXP2 || act == ll1er_pkg::ACT_EXP3)) begin
			we = 1'b1;
		end else if (cmd.push2) begin
			we    = 1'b1;
			waddr = sp_m2[ll1er_pkg::ADDR_W-1:0];
			wdata = pend_q;
		end
	end

	// stack memory with registered read of the entry under the top
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[sp_m2[ll1er_pkg::ADDR_W-1:0]];
	end

	// lookahead and pending push
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			la_q  <= end_of_text ? ll1er_pkg::SYM_END : classify(char_code);
			fin_q <= end_of_text;
		end
		if (cmd.eval) begin
			pend_q <= rhs1;
		end
		if (cmd.finish) begin
			status_q <= !fin_q ? ll1er_pkg::STATUS_BUSY :
				(err_q ? ll1er_pkg::STATUS_REJECT : ll1er_pkg::STATUS_ACCEPT);
		end
	end

	// top of stack, pointer and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= ll1er_pkg::SYM_E;
			sp_q  <= ll1er_pkg::SP_W'(2);
			err_q <= 1'b0;
		end else if (cmd.eval) begin
			case (act)
				ll1er_pkg::ACT_EXP1, ll1er_pkg::ACT_EXP2, ll1er_pkg::ACT_EXP3: begin
					top_q <= rhs_top;
					sp_q  <= new_sp_ext[ll1er_pkg::SP_W-1:0];
				end
				ll1er_pkg::ACT_POP, ll1er_pkg::ACT_MATCH: begin
					sp_q <= sp_m1;
				end
				ll1er_pkg::ACT_ERROR: begin
					err_q <= 1'b1;
				end
				default: begin
					err_q <= err_q;
				end
			endcase
		end else if (cmd.load) begin
			top_q <= (sp_q == ll1er_pkg::SP_W'(1)) ? ll1er_pkg::SYM_END : rdata_q;
		end else if (cmd.finish && fin_q) begin
			top_q <= ll1er_pkg::SYM_E;
			sp_q  <= ll1er_pkg::SP_W'(2);
			err_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.act      = act;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;

endmodule

FILE: rtl/ll1_expression_recognizer.sv
// LL(1) recognizer for + - * / expressions over i with parentheses, one text byte
// per item and one status item per input item: 0 for every ordinary byte, then
// 1 (accepted) or 2 (rejected) for the item that carries end_of_text, after which
// the stack starts over. Bytes other than ( ) i + - * / are skipped. Items are
// worked one at a time: an item is accepted in the idle state, then worked
// through the stack steps it causes, then its result is loaded. An expansion
// with at most two symbols or an error is a single evaluation step; an
// expansion with three symbols adds a push of the pending symbol, and an epsilon
// pop or a terminal match adds a load of the new top (one stack write port,
// registered read of the entry under the top register); a step that finds
// nothing left to do (a skipped byte, the end marker meeting the end marker,
// any byte after an error) is a single evaluation step as well; an end item
// also pops each pending E' and T'. The result is loaded only once the output
// register is free, so a result waiting on the output delays the finish of the
// next item and the acceptance of the item after it.
module ll1_expression_recognizer (
	input  logic         clk,
	input  logic         arst_n,
	ll1er_in_if.sink     in_ch,
	ll1er_out_if.source  out_ch
);

	ll1er_pkg::cmd_t  cmd;
	ll1er_pkg::stat_t stat;

	// sequencer
	ll1er_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack, lookahead and result register
	ll1er_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (in_ch.char_code),
		.end_of_text (in_ch.end_of_text),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.status      (out_ch.status)
	);

endmodule
